// ===== hdl/mrng_pkg.sv =====
// Package for the Manhattan ring neighbor generator.
// Holds the word types, the register index codes and the fixed sizes.
// It has no dependencies.
`timescale 1ns / 1ps

package mrng_pkg;

  // Fixed field widths and the largest radius that is served.
  localparam int COORD_BITS = 10;
  localparam int RING_BITS  = 3;
  localparam int MAX_RADIUS = 5;

  // Opcodes of an input word.
  typedef enum logic {
    OP_SINGLE_RING = 1'b0,
    OP_ALL_RINGS   = 1'b1
  } opcode_e;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_GRID_MAX_X = 1'b0,
    CFG_GRID_MAX_Y = 1'b1
  } cfg_idx_e;

  // Input word: one center cell request.
  typedef struct packed {
    logic                  opcode;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [RING_BITS-1:0]  radius;
  } in_word_t;

  // Output word: one neighbor cell or a marker.
  typedef struct packed {
    logic [COORD_BITS-1:0] neighbor_x;
    logic [COORD_BITS-1:0] neighbor_y;
    logic [RING_BITS-1:0]  ring;
    logic                  valid_res;
    logic                  error;
    logic                  last;
  } out_word_t;

endpackage

// ===== hdl/mrng_stream_if.sv =====
// Valid/ready stream channel for the ring neighbor generator.
// The payload type is a parameter; it is one of the words of mrng_pkg.
`timescale 1ns / 1ps

interface mrng_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  // The producer drives valid and payload, the consumer drives ready.
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ===== hdl/manhattan_ring_neighbor_generator_core.sv =====
// Top level of the Manhattan ring neighbor generator.
// Uses mrng_pkg for the word types and mrng_stream_if for both channels.
// The block takes one request word (center, radius, opcode) and walks every candidate offset of
// the requested rings through one shared add-and-compare unit, one candidate per cycle, in the
// fixed order (d,0), (-d,0), (0,d), (0,-d), then for x = d-1 down to 1 with y = d-x:
// (x,y), (x,-y), (-x,y), (-x,-y). Ring d has 4*d candidates, so a request for rings 1..r
// scans 2*r*(r+1) candidates, fewer for a single ring, and then flushes the final word. A request
// with radius 0 or above 5 goes straight to the flush state and gives a single marker word. One
// found cell is held back in a pending register so that the final one can carry last; a stall on
// the output holds the scan. The block accepts no new request until the final word of the current
// one has entered the output register. Grid limits are written through the configuration port;
// the user must write them only while the block is idle, and the block itself does not enforce it.
`timescale 1ns / 1ps

module manhattan_ring_neighbor_generator_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_idx_i,
  input  logic [mrng_pkg::COORD_BITS-1:0] cfg_data_i,
  mrng_stream_if.sink               in_i,
  mrng_stream_if.source             out_o
);

  import mrng_pkg::*;

  localparam int SumBits = COORD_BITS + 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  // Registers.
  state_e                state_q, state_d;
  logic [COORD_BITS-1:0] grid_max_x_q, grid_max_x_d;
  logic [COORD_BITS-1:0] grid_max_y_q, grid_max_y_d;
  logic [COORD_BITS-1:0] cx_q, cx_d;
  logic [COORD_BITS-1:0] cy_q, cy_d;
  logic [RING_BITS-1:0]  ring_q, ring_d;     // current ring d
  logic [RING_BITS-1:0]  ring_end_q, ring_end_d;
  logic [RING_BITS-1:0]  xo_q, xo_d;         // x magnitude; equals d on the axis step
  logic [1:0]            quad_q, quad_d;
  logic                  err_q, err_d;
  logic                  pend_v_q, pend_v_d;
  out_word_t             pend_q, pend_d;
  logic                  out_v_q, out_v_d;
  out_word_t             out_q, out_d;

  // Candidate offset and shared adder / range check.
  logic [RING_BITS-1:0] mag_x, mag_y;
  logic                 neg_x, neg_y;
  logic [SumBits-1:0]   sum_x, sum_y, ext_x, ext_y;
  logic                 cand_ok;
  out_word_t            cand;
  logic                 out_free;
  logic                 in_fire;

  // Offset of the current candidate from the sequencer position.
  always_comb begin
    if (xo_q == ring_q) begin
      mag_x = (quad_q[1] == 1'b0) ? ring_q : '0;
      neg_x = (quad_q == 2'd1);
      mag_y = (quad_q[1] == 1'b1) ? ring_q : '0;
      neg_y = (quad_q == 2'd3);
    end else begin
      mag_x = xo_q;
      neg_x = quad_q[1];
      mag_y = ring_q - xo_q;
      neg_y = quad_q[0];
    end
  end

  // One add and one limit compare per axis.
  always_comb begin
    ext_x = {{(SumBits-RING_BITS){1'b0}}, mag_x};
    ext_y = {{(SumBits-RING_BITS){1'b0}}, mag_y};
    sum_x = neg_x ? ({2'b00, cx_q} - ext_x) : ({2'b00, cx_q} + ext_x);
    sum_y = neg_y ? ({2'b00, cy_q} - ext_y) : ({2'b00, cy_q} + ext_y);
    cand_ok = !sum_x[SumBits-1] && !sum_y[SumBits-1]
              && (sum_x[SumBits-2:0] <= {1'b0, grid_max_x_q})
              && (sum_y[SumBits-2:0] <= {1'b0, grid_max_y_q});
    cand.neighbor_x = sum_x[COORD_BITS-1:0];
    cand.neighbor_y = sum_y[COORD_BITS-1:0];
    cand.ring       = ring_q;
    cand.valid_res  = 1'b1;
    cand.error      = 1'b0;
    cand.last       = 1'b0;
  end

  assign out_free    = !out_v_q || out_o.ready;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid = out_v_q;
  assign out_o.payload = out_q;

  // Sequencer, pending word and output register next values.
  always_comb begin
    state_d      = state_q;
    grid_max_x_d = grid_max_x_q;
    grid_max_y_d = grid_max_y_q;
    cx_d         = cx_q;
    cy_d         = cy_q;
    ring_d       = ring_q;
    ring_end_d   = ring_end_q;
    xo_d         = xo_q;
    quad_d       = quad_q;
    err_d        = err_q;
    pend_v_d     = pend_v_q;
    pend_d       = pend_q;
    out_v_d      = out_o.ready ? 1'b0 : out_v_q;
    out_d        = out_q;

    // Configuration writes.
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GRID_MAX_X: grid_max_x_d = cfg_data_i;
        CFG_GRID_MAX_Y: grid_max_y_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cx_d       = in_i.payload.center_x;
          cy_d       = in_i.payload.center_y;
          ring_end_d = in_i.payload.radius;
          pend_v_d   = 1'b0;
          err_d      = (in_i.payload.radius > RING_BITS'(MAX_RADIUS));
          quad_d     = '0;
          if (opcode_e'(in_i.payload.opcode) == OP_ALL_RINGS) begin
            ring_d = RING_BITS'(1);
            xo_d   = RING_BITS'(1);
          end else begin
            ring_d = in_i.payload.radius;
            xo_d   = in_i.payload.radius;
          end
          if (in_i.payload.radius == '0 || in_i.payload.radius > RING_BITS'(MAX_RADIUS)) begin
            state_d = ST_FLUSH;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // A hit with a full pending word needs room in the output register.
        if (!(cand_ok && pend_v_q && !out_free)) begin
          if (cand_ok) begin
            if (pend_v_q) begin
              out_v_d = 1'b1;
              out_d   = pend_q;
            end
            pend_v_d = 1'b1;
            pend_d   = cand;
          end
          // Step to the next candidate.
          if (quad_q != 2'd3) begin
            quad_d = quad_q + 2'd1;
          end else begin
            quad_d = '0;
            if (xo_q == RING_BITS'(1)) begin
              if (ring_q == ring_end_q) begin
                state_d = ST_FLUSH;
              end else begin
                ring_d = ring_q + RING_BITS'(1);
                xo_d   = ring_q + RING_BITS'(1);
              end
            end else begin
              xo_d = xo_q - RING_BITS'(1);
            end
          end
        end
      end

      ST_FLUSH: begin
        // Final word: the held cell, or a marker when nothing was found.
        if (out_free) begin
          out_v_d = 1'b1;
          if (pend_v_q) begin
            out_d      = pend_q;
            out_d.last = 1'b1;
          end else begin
            out_d       = '0;
            out_d.error = err_q;
            out_d.last  = 1'b1;
          end
          pend_v_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      grid_max_x_q <= '1;
      grid_max_y_q <= '1;
      cx_q         <= '0;
      cy_q         <= '0;
      ring_q       <= '0;
      ring_end_q   <= '0;
      xo_q         <= '0;
      quad_q       <= '0;
      err_q        <= 1'b0;
      pend_v_q     <= 1'b0;
      pend_q       <= '0;
      out_v_q      <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      grid_max_x_q <= grid_max_x_d;
      grid_max_y_q <= grid_max_y_d;
      cx_q         <= cx_d;
      cy_q         <= cy_d;
      ring_q       <= ring_d;
      ring_end_q   <= ring_end_d;
      xo_q         <= xo_d;
      quad_q       <= quad_d;
      err_q        <= err_d;
      pend_v_q     <= pend_v_d;
      pend_q       <= pend_d;
      out_v_q      <= out_v_d;
      out_q        <= out_d;
    end
  end

endmodule

// ===== tb/tb_manhattan_ring_neighbor_generator_core.sv =====
// Self-checking testbench for the Manhattan ring neighbor generator core.
// Depends on mrng_pkg, mrng_stream_if and manhattan_ring_neighbor_generator_core; the expected
// neighbor words are computed in a small tracker class and compared word by word.
`timescale 1ns / 1ps

module tb_manhattan_ring_neighbor_generator_core;
  import mrng_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 80;

  // Tracks the neighbor words each accepted request must produce, in order.
  class ring_tracker;
    logic [COORD_BITS-1:0] grid_x;
    logic [COORD_BITS-1:0] grid_y;
    out_word_t             cell_q[$];
    int                    mismatches;

    function new();
      grid_x     = '1;
      grid_y     = '1;
      mismatches = 0;
    endfunction

    // Appends one expected word at the tail.
    function void enqueue(out_word_t c);
      cell_q.insert(cell_q.size(), c);
    endfunction

    // Queues one candidate cell if it falls inside the grid.
    function void try_offset(int cx, int cy, int dx, int dy, int d);
      int        nx;
      int        ny;
      out_word_t c;
      nx = cx + dx;
      ny = cy + dy;
      if (nx < 0 || ny < 0 || nx > int'(grid_x) || ny > int'(grid_y)) return;
      c            = '0;
      c.neighbor_x = nx[COORD_BITS-1:0];
      c.neighbor_y = ny[COORD_BITS-1:0];
      c.ring       = d[RING_BITS-1:0];
      c.valid_res  = 1'b1;
      enqueue(c);
    endfunction

    // Expands one accepted request into its expected words.
    function void add_request(in_word_t w);
      int        base;
      int        first_ring;
      int        cx;
      int        cy;
      int        d;
      int        ox;
      out_word_t m;
      base = cell_q.size();
      m    = '0;
      // An oversized radius gives a single error marker.
      if (w.radius > MAX_RADIUS) begin
        m.error = 1'b1;
        m.last  = 1'b1;
        enqueue(m);
        return;
      end
      cx         = int'(w.center_x);
      cy         = int'(w.center_y);
      first_ring = (w.opcode == OP_ALL_RINGS) ? 1 : int'(w.radius);
      for (d = first_ring; d <= int'(w.radius); d++) begin
        if (d == 0) continue;
        try_offset(cx, cy, d, 0, d);
        try_offset(cx, cy, -d, 0, d);
        try_offset(cx, cy, 0, d, d);
        try_offset(cx, cy, 0, -d, d);
        for (ox = d - 1; ox >= 1; ox--) begin
          try_offset(cx, cy, ox, d - ox, d);
          try_offset(cx, cy, ox, ox - d, d);
          try_offset(cx, cy, -ox, d - ox, d);
          try_offset(cx, cy, -ox, ox - d, d);
        end
      end
      // No cell on the grid: a plain empty marker closes the request.
      if (cell_q.size() == base) begin
        m.last = 1'b1;
        enqueue(m);
      end else begin
        cell_q[cell_q.size()-1].last = 1'b1;
      end
    endfunction

    function void compare_field(string name, logic [15:0] e, logic [15:0] a);
      if (a !== e) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
      end
    endfunction

    // Checks one output word against the oldest expectation.
    function void check_cell(out_word_t got);
      out_word_t e;
      if (cell_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
        return;
      end
      e = cell_q.pop_front();
      compare_field("neighbor_x", 16'(e.neighbor_x), 16'(got.neighbor_x));
      compare_field("neighbor_y", 16'(e.neighbor_y), 16'(got.neighbor_y));
      compare_field("ring", 16'(e.ring), 16'(got.ring));
      compare_field("valid_res", 16'(e.valid_res), 16'(got.valid_res));
      compare_field("error", 16'(e.error), 16'(got.error));
      compare_field("last", 16'(e.last), 16'(got.last));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [0:0]            cfg_idx_i;
  logic [COORD_BITS-1:0] cfg_data_i;
  bit                    hold_req = 1'b0;
  int                    burst_left;
  int                    quiet_cycles = 0;
  ring_tracker           tracker = new();

  mrng_stream_if #(.payload_t(in_word_t))  in_if ();
  mrng_stream_if #(.payload_t(out_word_t)) out_if ();

  manhattan_ring_neighbor_generator_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Monitor: notes accepted requests, checks accepted words, and watches for a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) tracker.add_request(in_if.payload);
      if (out_if.valid && out_if.ready) tracker.check_cell(out_if.payload);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("** manhattan_ring_neighbor_generator_core: FAILED **");
        $finish;
      end
    end
  end

  // Receiver: switches between stall patterns and serves one long hold-off on request.
  initial begin : receiver
    int mode;
    int mode_left;
    int tick;
    mode      = 0;
    mode_left = 0;
    tick      = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        tick++;
        case (mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= 1'($urandom_range(0, 1));
          2:       out_if.ready <= (tick % 4 == 0);
          default: out_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  function automatic in_word_t make_word(opcode_e op, int x, int y, int r);
    in_word_t w;
    w.opcode   = op;
    w.center_x = x[COORD_BITS-1:0];
    w.center_y = y[COORD_BITS-1:0];
    w.radius   = r[RING_BITS-1:0];
    return w;
  endfunction

  // Picks a coordinate close to either grid border so that clipping happens often.
  function automatic int near_edge(int g);
    int t;
    if ($urandom_range(0, 1)) return int'($urandom_range(0, 6));
    t = g + int'($urandom_range(0, 10)) - 5;
    if (t < 0) t = 0;
    if (t > 1023) t = 1023;
    return t;
  endfunction

  function automatic in_word_t random_request();
    in_word_t w;
    int       k;
    w.opcode   = $urandom_range(0, 1) ? OP_ALL_RINGS : OP_SINGLE_RING;
    w.center_x = $urandom_range(0, 1) ? COORD_BITS'($urandom_range(0, 1023))
                                      : COORD_BITS'(near_edge(int'(tracker.grid_x)));
    w.center_y = $urandom_range(0, 1) ? COORD_BITS'($urandom_range(0, 1023))
                                      : COORD_BITS'(near_edge(int'(tracker.grid_y)));
    k          = $urandom_range(0, 19);
    if (k < 3) w.radius = RING_BITS'($urandom_range(6, 7));
    else if (k < 6) w.radius = RING_BITS'($urandom_range(0, 2));
    else w.radius = RING_BITS'($urandom_range(3, 5));
    return w;
  endfunction

  // Offers one request word and waits for it to be taken; gaps follow each burst.
  task automatic offer_request(input in_word_t w);
    int gap;
    in_if.valid   <= 1'b1;
    in_if.payload <= w;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_if.valid <= 1'b0;
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30) : $urandom_range(0, 4);
    end
  endtask

  task automatic run_random(input int count);
    repeat (count) offer_request(random_request());
  endtask

  // Stops offering and waits until every expected word has come out.
  task automatic finish_phase();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.cell_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Writes both grid limits while the block is idle.
  task automatic set_grid(input int mx, input int my);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_GRID_MAX_X;
    cfg_data_i <= mx[COORD_BITS-1:0];
    @(posedge clk_i);
    cfg_idx_i  <= CFG_GRID_MAX_Y;
    cfg_data_i <= my[COORD_BITS-1:0];
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    tracker.grid_x = mx[COORD_BITS-1:0];
    tracker.grid_y = my[COORD_BITS-1:0];
  endtask

  // Main sequence: directed requests, then random phases over several grid sizes.
  initial begin : stimulus
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_GRID_MAX_X;
    cfg_data_i    <= '0;
    in_if.valid   <= 1'b0;
    in_if.payload <= '0;
    burst_left    = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Full grid: empty and error markers, border clipping, the longest request.
    offer_request(make_word(OP_SINGLE_RING, 512, 512, 0));
    offer_request(make_word(OP_ALL_RINGS, 0, 1023, 0));
    offer_request(make_word(OP_SINGLE_RING, 100, 200, 6));
    offer_request(make_word(OP_ALL_RINGS, 1023, 1023, 7));
    offer_request(make_word(OP_ALL_RINGS, 0, 0, 5));
    offer_request(make_word(OP_ALL_RINGS, 1023, 1023, 5));
    offer_request(make_word(OP_ALL_RINGS, 512, 300, 5));
    offer_request(make_word(OP_SINGLE_RING, 0, 0, 1));
    offer_request(make_word(OP_SINGLE_RING, 1023, 0, 2));
    offer_request(make_word(OP_SINGLE_RING, 0, 1023, 3));
    offer_request(make_word(OP_SINGLE_RING, 4, 4, 4));
    offer_request(make_word(OP_SINGLE_RING, 1020, 2, 5));
    offer_request(make_word(OP_ALL_RINGS, 1, 1, 1));
    offer_request(make_word(OP_SINGLE_RING, 682, 341, 5));
    run_random(6);
    // Long receiver hold-off while requests keep coming.
    hold_req = 1'b1;
    run_random(10);
    finish_phase();

    // Single-cell grid: every cell off the grid, or just the origin.
    set_grid(0, 0);
    offer_request(make_word(OP_SINGLE_RING, 0, 0, 1));
    offer_request(make_word(OP_ALL_RINGS, 0, 0, 5));
    offer_request(make_word(OP_SINGLE_RING, 3, 2, 5));
    offer_request(make_word(OP_ALL_RINGS, 1023, 1023, 3));
    run_random(12);
    finish_phase();

    set_grid(1023, 0);
    run_random(14);
    finish_phase();

    set_grid(0, 1023);
    run_random(14);
    finish_phase();

    // Small grid with centers on and beyond its corner.
    set_grid(7, 5);
    offer_request(make_word(OP_ALL_RINGS, 7, 5, 5));
    offer_request(make_word(OP_SINGLE_RING, 3, 2, 4));
    offer_request(make_word(OP_ALL_RINGS, 1023, 0, 5));
    run_random(14);
    finish_phase();

    set_grid($urandom_range(0, 1023), $urandom_range(0, 1023));
    run_random(14);
    finish_phase();

    set_grid(1023, 1023);
    run_random(10);
    finish_phase();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.cell_q.size() == 0) begin
      $display("** manhattan_ring_neighbor_generator_core: PASSED **");
    end else begin
      if (tracker.cell_q.size() != 0)
        $display("%0t: %0d expected words never arrived", $time, tracker.cell_q.size());
      $display("** manhattan_ring_neighbor_generator_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mrng_pkg.sv
hdl/mrng_stream_if.sv
hdl/manhattan_ring_neighbor_generator_core.sv
tb/tb_manhattan_ring_neighbor_generator_core.sv
